/* rtl/cdp_pkg.sv */
// Shared constants and types of the capability descriptor parser.
package cdp_pkg;

   localparam int SVC_COUNT_DEFAULT = 192;
   localparam int IRQ_COUNT_DEFAULT = 1024;

   localparam int SVC_GROUP_W = 24;
   localparam int SVC_GROUPS  = 8;
   localparam int EPOCH_W     = 8;
   localparam int KIND_W      = 6;
   localparam int SEEN_W      = 17;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 120;

   typedef logic [2:0]        status_type;
   typedef logic [1:0]        action_type;
   typedef logic [KIND_W-1:0] kind_type;

   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_INVALID_ARG   = 3'd1;
   localparam status_type ST_INVALID_COMBO = 3'd2;
   localparam status_type ST_BAD_CORE      = 3'd3;
   localparam status_type ST_OUT_OF_RANGE  = 3'd4;
   localparam status_type ST_RESERVED      = 3'd5;

   localparam action_type ACT_PARSE     = 2'd0;
   localparam action_type ACT_QUERY_SVC = 2'd1;
   localparam action_type ACT_QUERY_IRQ = 2'd2;

   localparam kind_type KIND_NONE       = 6'd0;
   localparam kind_type KIND_PRIO_CORE  = 6'd3;
   localparam kind_type KIND_SYSCALL    = 6'd4;
   localparam kind_type KIND_MAP_PAIR   = 6'd6;
   localparam kind_type KIND_MAP_IO     = 6'd7;
   localparam kind_type KIND_MAP_REGION = 6'd10;
   localparam kind_type KIND_INTERRUPT  = 6'd11;
   localparam kind_type KIND_PROGRAM    = 6'd13;
   localparam kind_type KIND_VERSION    = 6'd14;
   localparam kind_type KIND_HANDLE     = 6'd15;
   localparam kind_type KIND_DEBUG      = 6'd16;
   localparam kind_type KIND_TOP        = 6'd16;
   localparam kind_type KIND_IGNORE     = 6'd32;

   localparam logic [SEEN_W-1:0] ONCE_MASK = 17'h1_E008;

   localparam logic [31:0] KERNEL_VERSION = 32'h0052_0000;
   localparam logic [31:0] VERSION_MIN    = 32'h0008_0000;
   localparam logic [3:0]  KERNEL_CORES   = 4'hF;
   localparam logic [7:0]  CORE_COUNT     = 8'd4;
   localparam logic [9:0]  IRQ_SKIP       = 10'h3FF;

endpackage

/* rtl/cdp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module cdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/capability_descriptor_parser_unit.sv */
// Capability descriptor parser: top level with input stage, decode and result register.
//
// req channel: one item per descriptor word or permission query. tuser carries the
// action, tlast marks the final word of a list, tdata the word, first_word and index.
// rsp channel: one item per request, showing the parse state after that request.
// csr channel: one-bit kernel_process register, always ready; write it while idle.
// A result passes the input register, then the result register. Throughput: one
// item per cycle while rsp_tready is high and no clearing pass runs, set by the
// single pass of decode logic between the two registers.
// Interrupt permissions live in two tag RAMs (one per interrupt slot of a word);
// an entry counts as set when its tag equals the current list epoch.
// Reset: control state clears and a clearing pass writes every tag RAM entry
// with req_tready low. Every 254th list start reuses an epoch, so that list's
// first word waits for another clearing pass.
// When rsp_tready is low, the result register holds and one more item waits in the
// input register; req_tready drops when both are full or a clearing pass runs or is due.
module capability_descriptor_parser_unit #(
   parameter int SVC_COUNT       = cdp_pkg::SVC_COUNT_DEFAULT,
   parameter int INTERRUPT_COUNT = cdp_pkg::IRQ_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_wdata,   // kernel_process
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // descriptor[31:0], first_word[32], query_index[42:33], zero pad[47:43]
   input  logic [cdp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,   // action
   input  logic                           req_tlast,   // last_word
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // status[2:0], list_failed[3], allowed_cores[7:4], allowed_priorities[71:8],
   // version_word[103:72], kind_of_program[106:104], handle_limit[116:107],
   // may_debug[117], may_force_debug[118], query_bit[119]
   output logic [cdp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IRQ_AW = $clog2(INTERRUPT_COUNT);
   localparam int EW     = cdp_pkg::EPOCH_W;
   localparam int GW     = cdp_pkg::SVC_GROUP_W;
   localparam int NG     = cdp_pkg::SVC_GROUPS;
   localparam logic [IRQ_AW-1:0] SWEEP_LAST = IRQ_AW'(INTERRUPT_COUNT - 1);
   localparam logic [10:0]       IRQ_LIMIT  = 11'(INTERRUPT_COUNT);
   localparam logic [9:0]        SVC_LIMIT  = 10'(SVC_COUNT);

   // input stage
   logic                        s1_valid_ff;
   cdp_pkg::action_type         s1_action_ff;
   logic [31:0]                 s1_desc_ff;
   logic                        s1_first_ff;
   logic                        s1_last_ff;
   logic [9:0]                  s1_qidx_ff;

   // parse state
   logic                        kproc_ff;
   logic [cdp_pkg::SEEN_W-1:0]  seen_kinds_ff, seen_kinds_in;
   logic [NG-1:0]               seen_groups_ff, seen_groups_in;
   logic [GW-1:0]               svc_ff [NG];
   logic [GW-1:0]               svc_in [NG];
   logic [3:0]                  core_ff, core_in;
   logic [63:0]                 prio_ff, prio_in;
   logic [31:0]                 version_ff, version_in;
   logic [2:0]                  prog_ff, prog_in;
   logic [9:0]                  handle_ff, handle_in;
   logic [1:0]                  debug_ff, debug_in;
   logic                        pair_ff, pair_in;
   logic                        failed_ff, failed_in;
   logic [EW-1:0]               epoch_ff, epoch_in;

   // tag clearing pass and write forwarding
   logic                        sweep_busy_ff;
   logic [IRQ_AW-1:0]           sweep_addr_ff;
   logic                        fwd0_we_ff, fwd1_we_ff;
   logic [IRQ_AW-1:0]           fwd0_addr_ff, fwd1_addr_ff;

   // result register
   logic                        out_valid_ff;
   logic [cdp_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                        accept, s1_go, out_free, wrap_need;
   logic                        is_parse, first_eff;
   cdp_pkg::kind_type           kind;
   cdp_pkg::status_type         status;
   logic [7:0]                  cmin, cmax;
   logic [5:0]                  pmin, pmax;
   logic [3:0]                  core_rng;
   logic [63:0]                 prio_rng;
   logic [GW-1:0]               svc_mask [NG];
   logic [2:0]                  grp;
   logic [9:0]                  v0, v1;
   logic                        skip0, skip1, oor0, oor1, fail0;
   logic                        irq_we0, irq_we1;
   logic [EW-1:0]               tag0, tag1;
   logic [7:0]                  q8, row_x24, prod;
   logic [4:0]                  q_hi;
   logic [2:0]                  q_row;
   logic [4:0]                  q_bit;
   logic                        svc_hit, irq_hit, qbit;

   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign is_parse   = s1_action_ff == cdp_pkg::ACT_PARSE;
   assign first_eff  = is_parse && s1_first_ff;
   assign wrap_need  = s1_valid_ff && first_eff && (epoch_ff == '1);
   assign s1_go      = s1_valid_ff && out_free && !sweep_busy_ff && !wrap_need;
   assign req_tready = !sweep_busy_ff && (!s1_valid_ff || s1_go);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // field extraction
   assign cmin = s1_desc_ff[23:16];
   assign cmax = s1_desc_ff[31:24];
   assign pmin = s1_desc_ff[15:10];
   assign pmax = s1_desc_ff[9:4];
   assign grp  = s1_desc_ff[31:29];
   assign v0   = s1_desc_ff[21:12];
   assign v1   = s1_desc_ff[31:22];

   assign skip0 = v0 == cdp_pkg::IRQ_SKIP;
   assign skip1 = v1 == cdp_pkg::IRQ_SKIP;
   assign oor0  = {1'b0, v0} >= IRQ_LIMIT;
   assign oor1  = {1'b0, v1} >= IRQ_LIMIT;
   assign fail0 = !skip0 && oor0;

   always_comb begin
      kind = cdp_pkg::KIND_IGNORE;
      for (int i = 31; i >= 0; i--) begin
         if (!s1_desc_ff[i]) begin
            kind = cdp_pkg::KIND_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         core_rng[i] = (8'(i) >= cmin) && (8'(i) <= cmax);
      end
      for (int i = 0; i < 64; i++) begin
         prio_rng[i] = (6'(i) >= pmin) && (6'(i) <= pmax);
      end
   end

   always_comb begin
      for (int r = 0; r < NG; r++) begin
         for (int i = 0; i < GW; i++) begin
            svc_mask[r][i] = (r * GW + i) < SVC_COUNT;
         end
      end
   end

   // syscall query: row = index / 24 via reciprocal, bit = remainder
   assign q8      = s1_qidx_ff[7:0];
   assign q_hi    = q8[7:3];
   assign prod    = 8'({3'b000, q_hi} * 8'd11);
   assign q_row   = prod[7:5];
   assign row_x24 = {1'b0, q_row, 4'b0000} + {2'b00, q_row, 3'b000};
   assign q_bit   = 5'(q8 - row_x24);
   assign svc_hit = (s1_qidx_ff < SVC_LIMIT) && svc_ff[q_row][q_bit];

   assign irq_hit = ({1'b0, s1_qidx_ff} < IRQ_LIMIT) &&
                    ((tag0 == epoch_ff) || (tag1 == epoch_ff) ||
                     (fwd0_we_ff && (fwd0_addr_ff == s1_qidx_ff[IRQ_AW-1:0])) ||
                     (fwd1_we_ff && (fwd1_addr_ff == s1_qidx_ff[IRQ_AW-1:0])));

   always_comb begin
      case (s1_action_ff)
         cdp_pkg::ACT_QUERY_SVC: qbit = svc_hit;
         cdp_pkg::ACT_QUERY_IRQ: qbit = irq_hit;
         default:                qbit = 1'b0;
      endcase
   end

   always_comb begin
      seen_kinds_in  = seen_kinds_ff;
      seen_groups_in = seen_groups_ff;
      svc_in         = svc_ff;
      core_in        = core_ff;
      prio_in        = prio_ff;
      version_in     = version_ff;
      prog_in        = prog_ff;
      handle_in      = handle_ff;
      debug_in       = debug_ff;
      pair_in        = pair_ff;
      failed_in      = failed_ff;
      epoch_in       = epoch_ff;
      status         = cdp_pkg::ST_OK;
      irq_we0        = 1'b0;
      irq_we1        = 1'b0;

      if (first_eff) begin
         seen_kinds_in  = '0;
         seen_groups_in = '0;
         for (int g = 0; g < NG; g++) begin
            svc_in[g] = '0;
         end
         core_in    = kproc_ff ? cdp_pkg::KERNEL_CORES : 4'h0;
         prio_in    = kproc_ff ? '1 : '0;
         version_in = kproc_ff ? cdp_pkg::KERNEL_VERSION : 32'h0;
         prog_in    = '0;
         handle_in  = '0;
         debug_in   = '0;
         pair_in    = 1'b0;
         failed_in  = 1'b0;
         epoch_in   = epoch_ff + 1'b1;
      end

      if (is_parse && !failed_in) begin
         if (pair_in) begin
            pair_in = 1'b0;
            if (kind != cdp_pkg::KIND_MAP_PAIR) begin
               status = cdp_pkg::ST_INVALID_COMBO;
            end
         end else if (kind == cdp_pkg::KIND_MAP_PAIR) begin
            if (s1_last_ff) begin
               status = cdp_pkg::ST_INVALID_COMBO;
            end else begin
               pair_in = 1'b1;
            end
         end else if (kind == cdp_pkg::KIND_NONE) begin
            status = cdp_pkg::ST_INVALID_ARG;
         end else if (kind == cdp_pkg::KIND_IGNORE) begin
            status = cdp_pkg::ST_OK;
         end else if (kind > cdp_pkg::KIND_TOP) begin
            status = cdp_pkg::ST_INVALID_ARG;
         end else if (cdp_pkg::ONCE_MASK[kind[4:0]] && seen_kinds_in[kind[4:0]]) begin
            status = cdp_pkg::ST_INVALID_COMBO;
         end else begin
            seen_kinds_in[kind[4:0]] = 1'b1;
            case (kind)
               cdp_pkg::KIND_PRIO_CORE: begin
                  if ((prio_in != '0) || (core_in != '0)) begin
                     status = cdp_pkg::ST_INVALID_ARG;
                  end else if ((cmin > cmax) || (pmin > pmax)) begin
                     status = cdp_pkg::ST_INVALID_COMBO;
                  end else if (cmax >= cdp_pkg::CORE_COUNT) begin
                     status = cdp_pkg::ST_BAD_CORE;
                  end else begin
                     core_in = core_rng;
                     prio_in = prio_rng;
                  end
               end
               cdp_pkg::KIND_SYSCALL: begin
                  if (seen_groups_in[grp]) begin
                     status = cdp_pkg::ST_INVALID_COMBO;
                  end else begin
                     seen_groups_in[grp] = 1'b1;
                     svc_in[grp] = svc_in[grp] | (s1_desc_ff[28:5] & svc_mask[grp]);
                  end
               end
               cdp_pkg::KIND_MAP_IO, cdp_pkg::KIND_MAP_REGION: begin
                  status = cdp_pkg::ST_OK;
               end
               cdp_pkg::KIND_INTERRUPT: begin
                  irq_we0 = !skip0 && !oor0;
                  irq_we1 = !fail0 && !skip1 && !oor1;
                  if (fail0 || (!skip1 && oor1)) begin
                     status = cdp_pkg::ST_OUT_OF_RANGE;
                  end
               end
               cdp_pkg::KIND_PROGRAM: begin
                  if (s1_desc_ff[31:17] != '0) begin
                     status = cdp_pkg::ST_RESERVED;
                  end else begin
                     prog_in = s1_desc_ff[16:14];
                  end
               end
               cdp_pkg::KIND_VERSION: begin
                  if ((version_in[31:19] != '0) || (s1_desc_ff < cdp_pkg::VERSION_MIN)) begin
                     status = cdp_pkg::ST_INVALID_ARG;
                  end else begin
                     version_in = s1_desc_ff;
                  end
               end
               cdp_pkg::KIND_HANDLE: begin
                  if (s1_desc_ff[31:26] != '0) begin
                     status = cdp_pkg::ST_RESERVED;
                  end else begin
                     handle_in = s1_desc_ff[25:16];
                  end
               end
               cdp_pkg::KIND_DEBUG: begin
                  if (s1_desc_ff[31:19] != '0) begin
                     status = cdp_pkg::ST_RESERVED;
                  end else begin
                     debug_in = s1_desc_ff[18:17];
                  end
               end
               default: begin
                  status = cdp_pkg::ST_INVALID_ARG;
               end
            endcase
         end
      end

      if (is_parse && s1_last_ff) begin
         pair_in = 1'b0;
      end
      if (status != cdp_pkg::ST_OK) begin
         failed_in = 1'b1;
      end

      out_data_in = {qbit, debug_in[1], debug_in[0], handle_in, prog_in, version_in,
                     prio_in, core_in, failed_in, status};
   end

   cdp_ram #(
      .WIDTH (EW),
      .DEPTH (INTERRUPT_COUNT)
   ) u_irq_tag0 (
      .clock   (clock),
      .wr_en   (sweep_busy_ff || (s1_go && irq_we0)),
      .wr_addr (sweep_busy_ff ? sweep_addr_ff : v0[IRQ_AW-1:0]),
      .wr_data (sweep_busy_ff ? '0 : epoch_in),
      .rd_en   (accept),
      .rd_addr (req_tdata[33 +: IRQ_AW]),
      .rd_data (tag0)
   );

   cdp_ram #(
      .WIDTH (EW),
      .DEPTH (INTERRUPT_COUNT)
   ) u_irq_tag1 (
      .clock   (clock),
      .wr_en   (sweep_busy_ff || (s1_go && irq_we1)),
      .wr_addr (sweep_busy_ff ? sweep_addr_ff : v1[IRQ_AW-1:0]),
      .wr_data (sweep_busy_ff ? '0 : epoch_in),
      .rd_en   (accept),
      .rd_addr (req_tdata[33 +: IRQ_AW]),
      .rd_data (tag1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         kproc_ff       <= 1'b0;
         seen_kinds_ff  <= '0;
         seen_groups_ff <= '0;
         for (int g = 0; g < NG; g++) begin
            svc_ff[g] <= '0;
         end
         core_ff        <= '0;
         prio_ff        <= '0;
         version_ff     <= '0;
         prog_ff        <= '0;
         handle_ff      <= '0;
         debug_ff       <= '0;
         pair_ff        <= 1'b0;
         failed_ff      <= 1'b0;
         epoch_ff       <= EW'(1);
         sweep_busy_ff  <= 1'b1;
         sweep_addr_ff  <= '0;
         fwd0_we_ff     <= 1'b0;
         fwd1_we_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            kproc_ff <= csr_wdata;
         end
         s1_valid_ff  <= accept || (s1_valid_ff && !s1_go);
         out_valid_ff <= s1_go || (out_valid_ff && !rsp_tready);
         if (accept) begin
            fwd0_we_ff <= s1_go && irq_we0;
            fwd1_we_ff <= s1_go && irq_we1;
         end
         if (s1_go) begin
            seen_kinds_ff  <= seen_kinds_in;
            seen_groups_ff <= seen_groups_in;
            svc_ff         <= svc_in;
            core_ff        <= core_in;
            prio_ff        <= prio_in;
            version_ff     <= version_in;
            prog_ff        <= prog_in;
            handle_ff      <= handle_in;
            debug_ff       <= debug_in;
            pair_ff        <= pair_in;
            failed_ff      <= failed_in;
         end
         if (sweep_busy_ff) begin
            if (sweep_addr_ff == SWEEP_LAST) begin
               sweep_busy_ff <= 1'b0;
               sweep_addr_ff <= '0;
               epoch_ff      <= EW'(1);
            end else begin
               sweep_addr_ff <= sweep_addr_ff + 1'b1;
            end
         end else if (wrap_need) begin
            sweep_busy_ff <= 1'b1;
            sweep_addr_ff <= '0;
         end else if (s1_go) begin
            epoch_ff <= epoch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_tuser;
         s1_desc_ff   <= req_tdata[31:0];
         s1_first_ff  <= req_tdata[32];
         s1_qidx_ff   <= req_tdata[42:33];
         s1_last_ff   <= req_tlast;
         fwd0_addr_ff <= v0[IRQ_AW-1:0];
         fwd1_addr_ff <= v1[IRQ_AW-1:0];
      end
      if (s1_go) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
